>>> rtl/core/mtag_pkg.sv
// Package for the memory traffic address generator.
// Holds widths, defaults, register indexes, shared structs and the xorshift step.
// No dependencies.
package mtag_pkg;

	localparam int ADDR_W     = 32;
	localparam int TOTAL_W    = 64;
	localparam int RNG_W      = 64;
	localparam int IDX_W      = 26;
	localparam int HOT_W      = 27;
	localparam int PAGES_W    = 21;
	localparam int SALT_W     = 23;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;

	localparam int PAGE_BYTES_DEF = 4096;
	localparam int LINE_BYTES_DEF = 64;
	localparam int MAX_PAGES_DEF  = 1048576;

	localparam logic [RNG_W-1:0] SEED_BASE = 64'h0123_4567_89ab_cdef;
	localparam logic [HOT_W-1:0] LINE_IDX_LIMIT = 27'd67108864;

	localparam logic [HOT_W-1:0]   HOT_LINES_RST    = 27'd4194304;
	localparam logic [PAGES_W-1:0] RANDOM_PAGES_RST = 21'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_WALK_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOT_LINES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_PAGES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_SALT    = 2'd3;

	typedef struct packed {
		logic accept;
		logic seq_step;
		logic draw_first;
		logic draw_second;
		logic rand_finish;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_mode;
		logic lines_zero;
		logic div_done;
		logic out_free;
	} dp_status_t;

	function automatic logic [RNG_W-1:0] xorshift64(input logic [RNG_W-1:0] x);
		logic [RNG_W-1:0] a;
		logic [RNG_W-1:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 7);
		return b ^ (b << 17);
	endfunction

endpackage

>>> rtl/core/mtag_ifs.sv
// Channel interfaces for the memory traffic address generator.
// Depends on mtag_pkg for payload widths.
interface mtag_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [mtag_pkg::CFG_IDX_W-1:0]      index;
	logic [mtag_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface mtag_req_if;
	logic valid;
	logic ready;
	logic start_over;
	modport source (output valid, output start_over, input ready);
	modport sink (input valid, input start_over, output ready);
endinterface

interface mtag_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [mtag_pkg::ADDR_W-1:0]       access_address;
	logic                              pass_last;
	logic [mtag_pkg::TOTAL_W-1:0]      access_total;
	modport source (output valid, output access_address, output pass_last,
		output access_total, input ready);
	modport sink (input valid, input access_address, input pass_last,
		input access_total, output ready);
endinterface

>>> rtl/core/mtag_div.sv
// Restoring serial remainder unit, one quotient bit per cycle.
// Depends on mtag_pkg for the dividend width.
module mtag_div #(
	parameter int DIV_W = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mtag_pkg::RNG_W-1:0]    dividend,
	input  logic [DIV_W-1:0]              divisor,
	output logic                          done,
	output logic [DIV_W-1:0]              remainder
);
	localparam int DvdW = mtag_pkg::RNG_W;
	localparam int CntW = $clog2(DvdW + 1);

	logic [DvdW-1:0]  dvd_q;
	logic [DIV_W-1:0] divisor_q;
	logic [DIV_W-1:0] rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             done_q;
	logic [DIV_W:0]   trial;

	assign trial = {rem_q, dvd_q[DvdW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(DvdW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q     <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, divisor_q}) begin
				rem_q <= DIV_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

>>> rtl/core/mtag_ctrl.sv
// Controller state machine of the address generator.
// Depends on mtag_pkg for the command and status structs.
module mtag_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mtag_pkg::dp_status_t   status,
	output mtag_pkg::ctrl_cmd_t    cmd
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_DRAW2 = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (status.walk_mode) begin
					cmd.draw_first = 1'b1;
					state_d = ST_DRAW2;
				end else if (status.lines_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.seq_step = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_DRAW2: begin
				cmd.draw_second = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.rand_finish = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> rtl/core/mtag_dp.sv
// Datapath of the address generator: configuration registers, generator state,
// remainder units and the output register. Depends on mtag_pkg and mtag_div.
module mtag_dp #(
	parameter int PAGE_BYTES = mtag_pkg::PAGE_BYTES_DEF,
	parameter int LINE_BYTES = mtag_pkg::LINE_BYTES_DEF,
	parameter int MAX_PAGES  = mtag_pkg::MAX_PAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [mtag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtag_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              start_over,
	input  mtag_pkg::ctrl_cmd_t               cmd,
	output mtag_pkg::dp_status_t              status,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [mtag_pkg::ADDR_W-1:0]       access_address,
	output logic                              pass_last,
	output logic [mtag_pkg::TOTAL_W-1:0]      access_total
);
	localparam int PerPageRaw = PAGE_BYTES / LINE_BYTES;
	localparam int PerPage    = (PerPageRaw == 0) ? 1 : PerPageRaw;
	localparam int LineDivW   = $clog2(PerPage + 1);
	localparam bit PerPagePow2 = (PerPage & (PerPage - 1)) == 0;

	localparam int AddrW  = mtag_pkg::ADDR_W;
	localparam int HotW   = mtag_pkg::HOT_W;
	localparam int IdxW   = mtag_pkg::IDX_W;
	localparam int PagesW = mtag_pkg::PAGES_W;
	localparam int RngW   = mtag_pkg::RNG_W;

	logic                        walk_mode_q;
	logic [HotW-1:0]             hot_lines_q;
	logic [PagesW-1:0]           random_pages_q;
	logic [mtag_pkg::SALT_W-1:0] seed_salt_q;

	logic [RngW-1:0]                rng_q;
	logic [IdxW-1:0]                idx_q;
	logic [mtag_pkg::TOTAL_W-1:0]   cnt_q;
	logic [RngW-1:0]                draw_a_q;
	logic [AddrW-1:0]               res_addr_q;
	logic                           res_last_q;

	logic                           out_valid_q;
	logic [AddrW-1:0]               out_addr_q;
	logic                           out_last_q;
	logic [mtag_pkg::TOTAL_W-1:0]   out_total_q;

	logic [HotW-1:0]     lines_c;
	logic [IdxW-1:0]     cur_idx;
	logic                seq_last;
	logic [PagesW-1:0]   pages_c;
	logic [RngW-1:0]     draw_next;
	logic [PagesW-1:0]   page_rem;
	logic [LineDivW-1:0] line_rem;
	logic                page_done;
	logic                line_done;
	logic [AddrW-1:0]    rand_addr;

	always_comb begin
		lines_c = (hot_lines_q > mtag_pkg::LINE_IDX_LIMIT) ? mtag_pkg::LINE_IDX_LIMIT
			: hot_lines_q;
		cur_idx = ({1'b0, idx_q} >= lines_c) ? '0 : idx_q;
		seq_last = (HotW'(cur_idx) + HotW'(1)) >= lines_c;
		if (32'(random_pages_q) > 32'(MAX_PAGES)) begin
			pages_c = PagesW'(MAX_PAGES);
		end else begin
			pages_c = random_pages_q;
		end
		if (pages_c == '0) begin
			pages_c = PagesW'(1);
		end
		draw_next = mtag_pkg::xorshift64(rng_q);
		rand_addr = AddrW'(32'(page_rem) * 32'(PAGE_BYTES))
			+ AddrW'(32'(line_rem) * 32'(LINE_BYTES));
	end

	mtag_div #(.DIV_W(PagesW)) u_page_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.draw_second),
		.dividend  (draw_a_q),
		.divisor   (pages_c),
		.done      (page_done),
		.remainder (page_rem)
	);

	// With a power-of-two line count the line within the page is a mask of the second draw.
	if (PerPagePow2) begin : g_line_mask
		logic [LineDivW-1:0] line_rem_q;

		always_ff @(posedge clk) begin
			if (cmd.draw_second) begin
				line_rem_q <= LineDivW'(draw_next & RngW'(PerPage - 1));
			end
		end

		assign line_rem  = line_rem_q;
		assign line_done = 1'b1;
	end else begin : g_line_div
		mtag_div #(.DIV_W(LineDivW)) u_line_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (cmd.draw_second),
			.dividend  (draw_next),
			.divisor   (LineDivW'(PerPage)),
			.done      (line_done),
			.remainder (line_rem)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_mode_q    <= 1'b0;
			hot_lines_q    <= mtag_pkg::HOT_LINES_RST;
			random_pages_q <= mtag_pkg::RANDOM_PAGES_RST;
			seed_salt_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				mtag_pkg::REG_WALK_MODE:    walk_mode_q    <= cfg_data[0];
				mtag_pkg::REG_HOT_LINES:    hot_lines_q    <= cfg_data[HotW-1:0];
				mtag_pkg::REG_RANDOM_PAGES: random_pages_q <= cfg_data[PagesW-1:0];
				mtag_pkg::REG_SEED_SALT:    seed_salt_q    <= cfg_data[mtag_pkg::SALT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q       <= mtag_pkg::SEED_BASE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && start_over) begin
				rng_q <= mtag_pkg::SEED_BASE ^ RngW'(seed_salt_q);
				idx_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.seq_step) begin
				idx_q <= seq_last ? '0 : cur_idx + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.draw_first || cmd.draw_second) begin
				rng_q <= draw_next;
			end
			if (cmd.rand_finish) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_first) begin
			draw_a_q <= draw_next;
		end
		if (cmd.seq_step) begin
			res_addr_q <= AddrW'(32'(cur_idx) * 32'(LINE_BYTES));
			res_last_q <= seq_last;
		end
		if (cmd.rand_finish) begin
			res_addr_q <= rand_addr;
			res_last_q <= 1'b0;
		end
		if (cmd.load) begin
			out_addr_q  <= res_addr_q;
			out_last_q  <= res_last_q;
			out_total_q <= cnt_q;
		end
	end

	assign status.walk_mode  = walk_mode_q;
	assign status.lines_zero = (hot_lines_q == '0);
	assign status.div_done   = page_done && line_done;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign access_address = out_addr_q;
	assign pass_last      = out_last_q;
	assign access_total   = out_total_q;
endmodule

>>> rtl/core/memory_traffic_address_generator.sv
// Top level of the memory traffic address generator.
// Depends on mtag_pkg, the channel interfaces, mtag_ctrl and mtag_dp.
//
//   Channel | Direction | Payload                                   | Handshake
//   cfg     | in        | index, data                               | valid/ready
//   req     | in        | start_over                                | valid/ready
//   rsp     | out       | access_address, pass_last, access_total   | valid/ready
//
// Sequential mode: after acceptance the controller steps through PREP, which registers the
// result, and LOAD, which moves it into the output register; an empty hot region goes from
// PREP back to idle with no result. Random mode: PREP and DRAW2 make the two xorshift draws,
// DIV waits for the 64-step serial page remainder and LOAD fills the output register.
// One request is in flight at a time; a new one is taken while a result waits in rsp
// and stalls before its output load until rsp is free. Reset is asynchronous, active low.
module memory_traffic_address_generator #(
	parameter int PAGE_BYTES = mtag_pkg::PAGE_BYTES_DEF,
	parameter int LINE_BYTES = mtag_pkg::LINE_BYTES_DEF,
	parameter int MAX_PAGES  = mtag_pkg::MAX_PAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mtag_cfg_if.sink   cfg,
	mtag_req_if.sink   req,
	mtag_rsp_if.source rsp
);
	mtag_pkg::ctrl_cmd_t  cmd;
	mtag_pkg::dp_status_t status;
	logic                 in_ready;

	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	mtag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mtag_dp #(
		.PAGE_BYTES (PAGE_BYTES),
		.LINE_BYTES (LINE_BYTES),
		.MAX_PAGES  (MAX_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.start_over     (req.start_over),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.access_address (rsp.access_address),
		.pass_last      (rsp.pass_last),
		.access_total   (rsp.access_total)
	);
endmodule

>>> bench/mtag_checker.sv
// Checker for the memory traffic address generator: watches the cfg, req and rsp channels.
// Keeps its own copy of the registers, walk state and xorshift state to predict each result.
// Depends on mtag_pkg and the channel interfaces in mtag_ifs.
module mtag_checker (
	input  logic  clk,
	input  logic  arst_n,
	mtag_cfg_if   cfg,
	mtag_req_if   req,
	mtag_rsp_if   rsp,
	output int    mismatches,
	output int    expected_left
);
	import mtag_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic               last;
		logic [TOTAL_W-1:0] total;
	} access_t;

	localparam logic [63:0] LINES_PER_PAGE = (PAGE_BYTES_DEF / LINE_BYTES_DEF == 0) ? 64'd1 :
		64'(PAGE_BYTES_DEF / LINE_BYTES_DEF);

	access_t expected_accesses[$];

	logic               walk_mode_q;
	logic [HOT_W-1:0]   hot_lines_q;
	logic [PAGES_W-1:0] pages_q;
	logic [SALT_W-1:0]  salt_q;
	logic [RNG_W-1:0]   rng_q;
	logic [IDX_W-1:0]   line_q;
	logic [TOTAL_W-1:0] count_q;

	function automatic logic [RNG_W-1:0] advance_rng(input logic [RNG_W-1:0] s);
		logic [RNG_W-1:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 7);
		return t ^ (t << 17);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t mtag_checker: %s got %h want %h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_WALK_MODE: walk_mode_q = data[0];
			REG_HOT_LINES: hot_lines_q = data[HOT_W-1:0];
			REG_RANDOM_PAGES: pages_q = data[PAGES_W-1:0];
			REG_SEED_SALT: salt_q = data[SALT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic predict_access(input logic start_over);
		logic [63:0] lines;
		logic [63:0] cur_line;
		logic [63:0] page_count;
		logic [63:0] page;
		logic [63:0] line;
		access_t     e;
		if (start_over) begin
			rng_q   = SEED_BASE ^ {{(RNG_W-SALT_W){1'b0}}, salt_q};
			line_q  = '0;
			count_q = '0;
		end
		e.last = 1'b0;
		if (!walk_mode_q) begin
			lines = 64'(hot_lines_q);
			if (lines > 64'(LINE_IDX_LIMIT))
				lines = 64'(LINE_IDX_LIMIT);
			if (lines == 0)
				return;
			if (64'(line_q) >= lines)
				line_q = '0;
			cur_line = 64'(line_q);
			e.addr = ADDR_W'(cur_line * 64'(LINE_BYTES_DEF));
			if (cur_line + 1 >= lines) begin
				e.last = 1'b1;
				line_q = '0;
			end else begin
				line_q = IDX_W'(cur_line + 1);
			end
		end else begin
			page_count = 64'(pages_q);
			if (page_count > 64'(MAX_PAGES_DEF))
				page_count = 64'(MAX_PAGES_DEF);
			if (page_count == 0)
				page_count = 64'd1;
			rng_q = advance_rng(rng_q);
			page  = rng_q % page_count;
			rng_q = advance_rng(rng_q);
			line  = rng_q % LINES_PER_PAGE;
			e.addr = ADDR_W'(page * 64'(PAGE_BYTES_DEF) + line * 64'(LINE_BYTES_DEF));
		end
		count_q = count_q + 1;
		e.total = count_q;
		expected_accesses.push_back(e);
	endtask

	task automatic check_result();
		access_t e;
		if (expected_accesses.size() == 0) begin
			report_mismatch("unexpected result, address", 64'(rsp.access_address), '0);
			return;
		end
		e = expected_accesses.pop_front();
		if (rsp.access_address !== e.addr)
			report_mismatch("access_address", 64'(rsp.access_address), 64'(e.addr));
		if (rsp.pass_last !== e.last)
			report_mismatch("pass_last", 64'(rsp.pass_last), 64'(e.last));
		if (rsp.access_total !== e.total)
			report_mismatch("access_total", rsp.access_total, e.total);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_mode_q = 1'b0;
			hot_lines_q = HOT_LINES_RST;
			pages_q     = RANDOM_PAGES_RST;
			salt_q      = '0;
			rng_q       = SEED_BASE;
			line_q      = '0;
			count_q     = '0;
			mismatches  = 0;
			expected_accesses.delete();
			expected_left <= 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (cfg.valid && cfg.ready)
				apply_write(cfg.index, cfg.data);
			if (req.valid && req.ready)
				predict_access(req.start_over);
			expected_left <= expected_accesses.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// Top of the memory traffic address generator testbench: clock, reset, stimulus and verdict.
// Instantiates the generator and mtag_checker side by side on shared channel interfaces.
// Depends on mtag_pkg, mtag_ifs, the generator RTL and bench/mtag_checker.sv.
module tb_top;
	import mtag_pkg::*;

	localparam int ITEM_TARGET    = 1350;
	localparam int DRAIN_CYCLES   = 90;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PATTERN} stall_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	mtag_cfg_if cfg_ch ();
	mtag_req_if req_ch ();
	mtag_rsp_if rsp_ch ();

	int mismatches;
	int expected_left;
	int hold_ticket = 0;
	int hold_served = 0;

	logic             mode_now;
	logic [HOT_W-1:0] hot_now;
	int               burst_left;
	int               counted;

	memory_traffic_address_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mtag_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_ch),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	always #5 clk = ~clk;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == REG_WALK_MODE)
			mode_now = data[0];
		if (idx == REG_HOT_LINES)
			hot_now = data[HOT_W-1:0];
	endtask

	task automatic send_item(input logic start_over, input bit last);
		int gap;
		req_ch.valid      <= 1'b1;
		req_ch.start_over <= start_over;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		gap = 0;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(1, 15);
		end
		if (!(mode_now == 1'b0 && hot_now == '0))
			counted++;
		if (last || gap > 0)
			req_ch.valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic send_run(input int n);
		for (int k = 0; k < n; k++)
			send_item($urandom_range(0, 15) == 0, k == n - 1);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: stall pattern of its own, plus a long hold-off on request.
	initial begin
		stall_mode_e mode;
		int          mode_left;
		int          hold_left;
		rsp_ch.ready = 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_served != hold_ticket) begin
				hold_served = hold_ticket;
				hold_left = LONG_HOLD;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				case (mode)
					STALL_NONE: rsp_ch.ready <= 1'b1;
					STALL_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
					STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
					default: rsp_ch.ready <= (mode_left % 4 != 0);
				endcase
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		int               phase;
		int               r;
		logic [HOT_W-1:0] hot_val;
		logic [26:0]      pages_val;
		logic [26:0]      salt_val;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.start_over = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_WALK_MODE;
		cfg_ch.data       = '0;
		mode_now          = 1'b0;
		hot_now           = HOT_LINES_RST;
		burst_left        = 1;
		counted           = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state, then a start-over.
		send_item(1'b0, 0);
		send_item(1'b0, 0);
		send_item(1'b1, 1);
		wait_idle();

		// Short region with wrap and last-line flag.
		write_reg(REG_HOT_LINES, 27'd3);
		cfg_ch.valid <= 1'b0;
		for (int k = 0; k < 4; k++)
			send_item(1'b0, k == 3);
		wait_idle();

		write_reg(REG_HOT_LINES, 27'd1);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b0, 1);
		wait_idle();

		// Empty region: no result, start-over still clears state.
		write_reg(REG_HOT_LINES, 27'd0);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b1, 1);
		wait_idle();

		// Region shrinks below the current line index.
		write_reg(REG_HOT_LINES, 27'd10);
		cfg_ch.valid <= 1'b0;
		for (int k = 0; k < 5; k++)
			send_item(1'b0, k == 4);
		wait_idle();
		write_reg(REG_HOT_LINES, 27'd3);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b0, 1);
		wait_idle();

		// Oversized region is clipped.
		write_reg(REG_HOT_LINES, 27'h7FF_FFFF);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b0, 1);
		wait_idle();

		// Random mode: zero page count, oversized page count, full salt.
		write_reg(REG_WALK_MODE, 27'd1);
		write_reg(REG_RANDOM_PAGES, 27'd0);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b0, 1);
		wait_idle();
		write_reg(REG_RANDOM_PAGES, 27'h7FF_FFFF);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b0, 1);
		wait_idle();
		write_reg(REG_RANDOM_PAGES, 27'd1048576);
		write_reg(REG_SEED_SALT, 27'h7F_FFFF);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 0);
		send_item(1'b1, 1);
		wait_idle();

		// Back to sequential mode with the largest legal region.
		write_reg(REG_WALK_MODE, 27'd0);
		write_reg(REG_HOT_LINES, 27'd67108864);
		cfg_ch.valid <= 1'b0;
		send_item(1'b0, 1);
		wait_idle();

		counted = 0;
		phase = 0;
		while (counted < ITEM_TARGET) begin
			phase++;
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_WALK_MODE, 27'($urandom()));
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 15);
				case (r)
					0: hot_val = '0;
					1: hot_val = 27'd1;
					2: hot_val = 27'h7FF_FFFF;
					3: hot_val = 27'd67108864;
					4, 5: hot_val = 27'($urandom());
					default: hot_val = 27'($urandom_range(2, 40));
				endcase
				write_reg(REG_HOT_LINES, hot_val);
			end
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 9);
				case (r)
					0: pages_val = '0;
					1: pages_val = 27'd1;
					2: pages_val = 27'($urandom());
					3: pages_val = 27'd1048576;
					4: pages_val = 27'h1F_FFFF;
					default: pages_val = 27'($urandom_range(1, 1048576));
				endcase
				write_reg(REG_RANDOM_PAGES, pages_val);
			end
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 7);
				case (r)
					0: salt_val = '0;
					1: salt_val = 27'h7F_FFFF;
					2: salt_val = 27'($urandom());
					default: salt_val = 27'($urandom_range(0, 23'h7F_FFFF));
				endcase
				write_reg(REG_SEED_SALT, salt_val);
			end
			cfg_ch.valid <= 1'b0;
			if (phase % 6 == 3)
				hold_ticket++;
			send_run($urandom_range(10, 50));
			wait_idle();
		end

		if (mismatches == 0 && expected_left == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/mtag_pkg.sv
rtl/core/mtag_ifs.sv
rtl/core/mtag_div.sv
rtl/core/mtag_ctrl.sv
rtl/core/mtag_dp.sv
rtl/core/memory_traffic_address_generator.sv
bench/mtag_checker.sv
bench/tb_top.sv
